### hw/rtl/kdo_pkg.sv
// Package for the k-nearest-neighbor outlier block: word types, cell entry types,
// control structs, register indexes and sequencer states.
// No dependencies; every other file of the block imports it.
package kdo_pkg;

  localparam int ID_W       = 16;
  localparam int ATTR_W     = 16;
  localparam int SCORE_W    = 35;
  localparam int CFG_DATA_W = 5;
  localparam int CFG_IDX_W  = 2;

  // Input word: one attribute of one point.
  typedef struct packed {
    logic [ID_W-1:0]          point_id;
    logic signed [ATTR_W-1:0] attr_value;
    logic                     last_item;
  } in_word_t;

  // Result word: one reported outlier.
  typedef struct packed {
    logic [ID_W-1:0]    outlier_id;
    logic [SCORE_W-1:0] outlier_score;
    logic               last_result;
  } out_word_t;

  // One entry of the sorted neighbor list.
  typedef struct packed {
    logic               valid;
    logic [SCORE_W-1:0] distance;
  } heap_ent_t;

  typedef struct packed {
    logic clr;
    logic ins;
  } heap_ctl_t;

  // One entry of the ranked outlier list.
  typedef struct packed {
    logic               valid;
    logic [ID_W-1:0]    id;
    logic [SCORE_W-1:0] score;
  } rank_ent_t;

  typedef struct packed {
    logic clr;
    logic ins;
    logic pop;
    logic full;
    logic tie;
  } rank_ctl_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NEIGHBOUR_COUNT = 2'd0,
    CFG_OUTLIER_COUNT   = 2'd1,
    CFG_DIMS_IN_USE     = 2'd2
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_P_RD,
    ST_P_LAT,
    ST_Q_RD,
    ST_Q_LAT,
    ST_D_RD,
    ST_D_SUB,
    ST_D_SQ,
    ST_D_ACC,
    ST_OFFER,
    ST_CHECK,
    ST_P_DONE,
    ST_P_NEXT,
    ST_REPORT
  } state_t;

endpackage

### hw/rtl/kdo_heap_cell.sv
// One cell of the sorted nearest-neighbor list (ascending distance).
// Depends on kdo_pkg.
module kdo_heap_cell (
  input  logic                         clk,
  input  logic                         rst_n,
  input  kdo_pkg::heap_ctl_t           ctl,
  input  logic                         en,
  input  logic [kdo_pkg::SCORE_W-1:0]  dist_in,
  input  kdo_pkg::heap_ent_t           prev_ent,
  input  logic                         prev_gt,
  output kdo_pkg::heap_ent_t           ent,
  output logic                         gt
);
  import kdo_pkg::*;

  heap_ent_t ent_r, ent_nxt;

  // The offered distance goes below this entry when the entry is empty or larger.
  assign gt  = !ent_r.valid || (ent_r.distance > dist_in);
  assign ent = ent_r;

  // Insertion: the first larger cell takes the new distance, later ones shift up.
  always_comb begin
    ent_nxt = ent_r;
    if (ctl.clr) begin
      ent_nxt.valid = 1'b0;
    end else if (ctl.ins && gt) begin
      if (!prev_gt) begin
        ent_nxt.valid    = 1'b1;
        ent_nxt.distance = dist_in;
      end else begin
        ent_nxt = prev_ent;
      end
      if (!en) begin
        ent_nxt.valid = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r.valid <= 1'b0;
    end else begin
      ent_r <= ent_nxt;
    end
  end

endmodule

### hw/rtl/kdo_rank_cell.sv
// One cell of the ranked outlier list, ordered by descending score and then by arrival.
// Depends on kdo_pkg.
module kdo_rank_cell (
  input  logic                         clk,
  input  logic                         rst_n,
  input  kdo_pkg::rank_ctl_t           ctl,
  input  kdo_pkg::rank_ent_t           new_ent,
  input  logic [kdo_pkg::SCORE_W-1:0]  last_score,
  input  kdo_pkg::rank_ent_t           prev_ent,
  input  logic                         prev_ge,
  input  logic                         prev_eq,
  input  kdo_pkg::rank_ent_t           next_ent,
  output kdo_pkg::rank_ent_t           ent,
  output logic                         ge,
  output logic                         eq
);
  import kdo_pkg::*;

  rank_ent_t ent_r, ent_nxt;

  // Local compares against the candidate and against the weakest score.
  assign ge  = ent_r.valid && (ent_r.score >= new_ent.score);
  assign eq  = ent_r.valid && (ent_r.score == last_score);
  assign ent = ent_r;

  // Insert while not full, replace on a tie with the weakest, replace below a stronger entry, or pop.
  always_comb begin
    ent_nxt = ent_r;
    if (ctl.clr) begin
      ent_nxt.valid = 1'b0;
    end else if (ctl.pop) begin
      ent_nxt = next_ent;
    end else if (ctl.ins) begin
      if (!ctl.full) begin
        if (!ge && prev_ge) begin
          ent_nxt = new_ent;
        end else if (!ge && prev_ent.valid) begin
          ent_nxt = prev_ent;
        end
      end else if (ctl.tie) begin
        // The oldest weakest entry drops out; the rest of its group moves down.
        if (eq && !next_ent.valid) begin
          ent_nxt = new_ent;
        end else if (eq) begin
          ent_nxt = next_ent;
        end
      end else begin
        if (!ge && prev_ge) begin
          ent_nxt = new_ent;
        end else if (!ge && !prev_eq) begin
          ent_nxt = prev_ent;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r.valid <= 1'b0;
    end else begin
      ent_r <= ent_nxt;
    end
  end

endmodule

### hw/rtl/knn_distance_outlier_topn_top.sv
// Top level of the k-nearest-neighbor distance outlier block: loader, point memories,
// search sequencer, neighbor cell chain and ranked outlier cell chain.
// Depends on kdo_pkg, kdo_heap_cell and kdo_rank_cell.
//
//   port group  | direction | handshake        | word
//   in_*        | input     | in_valid/in_stall | kdo_pkg::in_word_t
//   out_*       | output    | out_valid/out_stall | kdo_pkg::out_word_t
//   cfg_*       | input     | cfg_we           | cfg_index, cfg_data
//
// Loading takes one word per cycle while in_stall is low. After the word with last_item
// the search runs alone: per point a metadata read, per other point a metadata read and,
// if taken, per dimension a read, subtract, square and accumulate, an offer and a check
// that may end the scan; it is bound by the single attribute read pair and one multiplier.
// The report then gives one word per cycle while out_stall is low.
// Reset (rst_n low, synchronous) empties both cell chains and the dataset; the memories
// need no clearing. in_stall stays high from the last word until the report is taken.
module knn_distance_outlier_topn_top #(
  parameter int MAX_POINTS   = 256,
  parameter int MAX_DIMS     = 8,
  parameter int MAX_K        = 16,
  parameter int MAX_OUTLIERS = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  kdo_pkg::in_word_t               in_word,
  output logic                            out_valid,
  input  logic                            out_stall,
  output kdo_pkg::out_word_t              out_word,
  input  logic                            cfg_we,
  input  logic [kdo_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [kdo_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import kdo_pkg::*;

  localparam int PT_W   = $clog2(MAX_POINTS);
  localparam int PC_W   = $clog2(MAX_POINTS + 1);
  localparam int DC_W   = $clog2(MAX_DIMS + 1);
  localparam int KC_W   = $clog2(MAX_K + 1);
  localparam int OC_W   = $clog2(MAX_OUTLIERS + 1);
  localparam int ADDR_W = $clog2(MAX_POINTS * MAX_DIMS);

  // Point memories.
  logic signed [ATTR_W-1:0] attr_mem [MAX_POINTS*MAX_DIMS];
  logic [ID_W-1:0]          id_mem   [MAX_POINTS];
  logic [DC_W-1:0]          len_mem  [MAX_POINTS];

  state_t state_r, state_nxt;

  logic [4:0] nc_r;
  logic [3:0] oc_r;
  logic [3:0] dims_r;
  logic [KC_W-1:0] k_eff;
  logic [OC_W-1:0] n_eff;
  logic [DC_W-1:0] dims_eff;

  logic [DC_W-1:0] attr_pos_r;
  logic            taken_r;
  logic [PC_W-1:0] pl_r;
  logic [ID_W-1:0] cur_id_r;
  logic [PC_W-1:0] npts_r;

  logic [PC_W-1:0] p_r, q_r;
  logic [DC_W-1:0] d_r;
  logic [ID_W-1:0] id_p_r;
  logic [DC_W-1:0] len_p_r, len_q_r;
  logic [ID_W-1:0] meta_id_r;
  logic [DC_W-1:0] meta_len_r;
  logic signed [ATTR_W-1:0] attr_a_r, attr_b_r;
  logic [ATTR_W-1:0] absd_r;
  logic [2*ATTR_W-1:0] sq_r;
  logic [SCORE_W-1:0] acc_r;
  logic [SCORE_W-1:0] cutoff_r;
  logic replaced_r;
  logic [OC_W-1:0] rank_cnt_r;

  logic in_acc, out_acc;
  logic pos0, taken_now, mem_we, end_pt;
  logic [ID_W-1:0] wr_id;
  logic [DC_W-1:0] pos_inc;
  logic [PT_W-1:0] meta_addr;
  logic [ADDR_W-1:0] wr_addr, rd_addr_a, rd_addr_b;

  logic signed [ATTR_W-1:0] a_m, b_m;
  logic signed [ATTR_W:0]   diff;
  logic [ATTR_W:0]          absd;

  heap_ctl_t heap_ctl;
  rank_ctl_t rank_ctl;
  rank_ent_t rank_new;
  logic [SCORE_W-1:0] heap_max, rank_last;
  logic rank_full, rank_tie, rank_take;

  heap_ent_t heap_ent      [MAX_K];
  heap_ent_t heap_prev_ent [MAX_K];
  logic      heap_gt       [MAX_K];
  logic      heap_prev_gt  [MAX_K];
  logic [SCORE_W-1:0] heap_tail [MAX_K];
  logic [MAX_K-1:0]   heap_valid;

  rank_ent_t rank_ent     [MAX_OUTLIERS];
  rank_ent_t rank_prev    [MAX_OUTLIERS];
  rank_ent_t rank_nx      [MAX_OUTLIERS];
  logic      rank_ge      [MAX_OUTLIERS];
  logic      rank_eq      [MAX_OUTLIERS];
  logic      rank_prev_ge [MAX_OUTLIERS];
  logic      rank_prev_eq [MAX_OUTLIERS];
  logic [SCORE_W-1:0] rank_tail [MAX_OUTLIERS];
  logic [MAX_OUTLIERS-1:0] rank_valid;

  // Configuration registers and their clamped working values.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nc_r   <= 5'd5;
      oc_r   <= 4'd8;
      dims_r <= 4'd8;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_NEIGHBOUR_COUNT: nc_r   <= cfg_data;
        CFG_OUTLIER_COUNT:   oc_r   <= cfg_data[3:0];
        CFG_DIMS_IN_USE:     dims_r <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (nc_r == '0) k_eff = KC_W'(1);
    else if (32'(nc_r) > MAX_K) k_eff = KC_W'(MAX_K);
    else k_eff = KC_W'(nc_r);
    if (oc_r == '0) n_eff = OC_W'(1);
    else if (32'(oc_r) > MAX_OUTLIERS) n_eff = OC_W'(MAX_OUTLIERS);
    else n_eff = OC_W'(oc_r);
    if (dims_r == '0) dims_eff = DC_W'(1);
    else if (32'(dims_r) > MAX_DIMS) dims_eff = DC_W'(MAX_DIMS);
    else dims_eff = DC_W'(dims_r);
  end

  // Handshakes.
  assign in_stall  = (state_r != ST_LOAD);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = (state_r == ST_REPORT) && rank_ent[0].valid;
  assign out_acc   = out_valid && !out_stall;

  assign out_word.outlier_id    = rank_ent[0].id;
  assign out_word.outlier_score = rank_ent[0].score;
  assign out_word.last_result   = !rank_nx[0].valid;

  // Loader: a point is taken on its first word while there is room for it.
  assign pos0      = (attr_pos_r == '0);
  assign taken_now = pos0 ? (32'(pl_r) < MAX_POINTS) : taken_r;
  assign wr_id     = pos0 ? in_word.point_id : cur_id_r;
  assign mem_we    = in_acc && taken_now;
  assign pos_inc   = attr_pos_r + DC_W'(1);
  assign end_pt    = (pos_inc >= dims_eff);
  assign wr_addr   = ADDR_W'(pl_r[PT_W-1:0] * MAX_DIMS + attr_pos_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_pos_r <= '0;
      taken_r    <= 1'b0;
      pl_r       <= '0;
    end else if (in_acc) begin
      if (in_word.last_item) begin
        attr_pos_r <= '0;
        taken_r    <= 1'b0;
        pl_r       <= '0;
      end else if (end_pt) begin
        attr_pos_r <= '0;
        taken_r    <= 1'b0;
        pl_r       <= pl_r + PC_W'(taken_now);
      end else begin
        attr_pos_r <= pos_inc;
        taken_r    <= taken_now;
      end
    end
  end

  // A partial last point still counts, so the total is the count plus this point if it was taken.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cur_id_r <= wr_id;
      if (in_word.last_item) begin
        npts_r <= pl_r + PC_W'(taken_now);
      end
    end
  end

  // Memory ports: one write, one metadata read and two attribute reads, all registered.
  assign meta_addr = (state_r == ST_P_RD) ? p_r[PT_W-1:0] : q_r[PT_W-1:0];
  assign rd_addr_a = ADDR_W'(p_r[PT_W-1:0] * MAX_DIMS + d_r);
  assign rd_addr_b = ADDR_W'(q_r[PT_W-1:0] * MAX_DIMS + d_r);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      attr_mem[wr_addr]          <= in_word.attr_value;
      id_mem[pl_r[PT_W-1:0]]     <= wr_id;
      len_mem[pl_r[PT_W-1:0]]    <= pos_inc;
    end
    meta_id_r  <= id_mem[meta_addr];
    meta_len_r <= len_mem[meta_addr];
    attr_a_r   <= attr_mem[rd_addr_a];
    attr_b_r   <= attr_mem[rd_addr_b];
  end

  // Attributes past what a point was given read as zero.
  assign a_m  = (d_r < len_p_r) ? attr_a_r : '0;
  assign b_m  = (d_r < len_q_r) ? attr_b_r : '0;
  assign diff = {a_m[ATTR_W-1], a_m} - {b_m[ATTR_W-1], b_m};
  assign absd = diff[ATTR_W] ? (ATTR_W+1)'(-diff) : diff;

  // Candidate offered to the ranked list at the end of a point.
  assign rank_full = (rank_cnt_r >= n_eff);
  assign rank_tie  = rank_full && (heap_max == rank_last);
  assign rank_take = !rank_full || (heap_max >= rank_last);
  assign rank_new.valid = 1'b1;
  assign rank_new.id    = id_p_r;
  assign rank_new.score = heap_max;

  // Sequencer: next state and cell controls.
  always_comb begin
    state_nxt     = state_r;
    heap_ctl      = '0;
    rank_ctl      = '0;
    rank_ctl.full = rank_full;
    rank_ctl.tie  = rank_tie;
    case (state_r)
      ST_LOAD: begin
        if (in_acc && in_word.last_item) state_nxt = ST_P_RD;
      end
      ST_P_RD: begin
        heap_ctl.clr = 1'b1;
        state_nxt = (p_r == npts_r) ? ST_REPORT : ST_P_LAT;
      end
      ST_P_LAT: state_nxt = ST_Q_RD;
      ST_Q_RD: state_nxt = (q_r == npts_r) ? ST_P_DONE : ST_Q_LAT;
      ST_Q_LAT: state_nxt = (meta_id_r == id_p_r) ? ST_Q_RD : ST_D_RD;
      ST_D_RD: state_nxt = ST_D_SUB;
      ST_D_SUB: state_nxt = ST_D_SQ;
      ST_D_SQ: state_nxt = ST_D_ACC;
      ST_D_ACC: state_nxt = (d_r + DC_W'(1) >= dims_eff) ? ST_OFFER : ST_D_RD;
      ST_OFFER: begin
        heap_ctl.ins = 1'b1;
        state_nxt = ST_CHECK;
      end
      ST_CHECK: state_nxt = (heap_max < cutoff_r) ? ST_P_DONE : ST_Q_RD;
      ST_P_DONE: begin
        rank_ctl.ins = rank_take;
        state_nxt = ST_P_NEXT;
      end
      ST_P_NEXT: state_nxt = ST_P_RD;
      ST_REPORT: begin
        if (!rank_ent[0].valid || (out_acc && out_word.last_result)) begin
          rank_ctl.clr = 1'b1;
          state_nxt = ST_LOAD;
        end else if (out_acc) begin
          rank_ctl.pop = 1'b1;
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Search counters and the distance datapath.
  always_ff @(posedge clk) begin
    case (state_r)
      ST_LOAD: p_r <= '0;
      ST_P_LAT: begin
        id_p_r  <= meta_id_r;
        len_p_r <= meta_len_r;
        q_r     <= '0;
      end
      ST_Q_LAT: begin
        len_q_r <= meta_len_r;
        d_r     <= '0;
        acc_r   <= '0;
        if (meta_id_r == id_p_r) q_r <= q_r + PC_W'(1);
      end
      ST_D_SUB: absd_r <= absd[ATTR_W-1:0];
      ST_D_SQ: sq_r <= absd_r * absd_r;
      ST_D_ACC: begin
        acc_r <= acc_r + SCORE_W'(sq_r);
        d_r   <= d_r + DC_W'(1);
      end
      ST_CHECK: q_r <= q_r + PC_W'(1);
      ST_P_NEXT: p_r <= p_r + PC_W'(1);
      default: ;
    endcase
  end

  // Ranked list bookkeeping: fill count, replacement flag and the search cutoff.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rank_cnt_r <= '0;
      cutoff_r   <= '0;
      replaced_r <= 1'b0;
    end else begin
      if (rank_ctl.clr) begin
        rank_cnt_r <= '0;
        cutoff_r   <= '0;
      end else if (rank_ctl.pop) begin
        rank_cnt_r <= rank_cnt_r - OC_W'(1);
      end else if (rank_ctl.ins && !rank_full) begin
        rank_cnt_r <= rank_cnt_r + OC_W'(1);
      end
      if (state_r == ST_P_DONE) begin
        replaced_r <= rank_ctl.ins && rank_full;
      end
      if (state_r == ST_P_NEXT && replaced_r) begin
        cutoff_r <= rank_last;
      end
    end
  end

  // Neighbor chain.
  for (genvar i = 0; i < MAX_K; i++) begin : g_heap
    if (i == 0) begin : g_first
      assign heap_prev_ent[i] = '0;
      assign heap_prev_gt[i]  = 1'b0;
    end else begin : g_rest
      assign heap_prev_ent[i] = heap_ent[i-1];
      assign heap_prev_gt[i]  = heap_gt[i-1];
    end
    if (i == MAX_K - 1) begin : g_tail_end
      assign heap_tail[i] = heap_ent[i].valid ? heap_ent[i].distance : '0;
    end else begin : g_tail_mid
      assign heap_tail[i] = (heap_ent[i].valid && !heap_ent[i+1].valid) ?
                            heap_ent[i].distance : '0;
    end
    assign heap_valid[i] = heap_ent[i].valid;

    kdo_heap_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (heap_ctl),
      .en       (k_eff > KC_W'(i)),
      .dist_in  (acc_r),
      .prev_ent (heap_prev_ent[i]),
      .prev_gt  (heap_prev_gt[i]),
      .ent      (heap_ent[i]),
      .gt       (heap_gt[i])
    );
  end

  // The largest kept distance sits in the last filled cell.
  always_comb begin
    heap_max = '0;
    for (int i = 0; i < MAX_K; i++) heap_max = heap_max | heap_tail[i];
  end

  // Ranked outlier chain.
  for (genvar i = 0; i < MAX_OUTLIERS; i++) begin : g_rank
    if (i == 0) begin : g_first
      assign rank_prev[i]    = '0;
      assign rank_prev_ge[i] = 1'b1;
      assign rank_prev_eq[i] = 1'b0;
    end else begin : g_rest
      assign rank_prev[i]    = rank_ent[i-1];
      assign rank_prev_ge[i] = rank_ge[i-1];
      assign rank_prev_eq[i] = rank_eq[i-1];
    end
    if (i == MAX_OUTLIERS - 1) begin : g_tail_end
      assign rank_nx[i]   = '0;
    end else begin : g_tail_mid
      assign rank_nx[i]   = rank_ent[i+1];
    end
    assign rank_tail[i]  = (rank_ent[i].valid && !rank_nx[i].valid) ?
                           rank_ent[i].score : '0;
    assign rank_valid[i] = rank_ent[i].valid;

    kdo_rank_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (rank_ctl),
      .new_ent    (rank_new),
      .last_score (rank_last),
      .prev_ent   (rank_prev[i]),
      .prev_ge    (rank_prev_ge[i]),
      .prev_eq    (rank_prev_eq[i]),
      .next_ent   (rank_nx[i]),
      .ent        (rank_ent[i]),
      .ge         (rank_ge[i]),
      .eq         (rank_eq[i])
    );
  end

  // The weakest score sits in the last filled cell.
  always_comb begin
    rank_last = '0;
    for (int i = 0; i < MAX_OUTLIERS; i++) rank_last = rank_last | rank_tail[i];
  end

  // During a search the neighbor list never holds more than k distances; the list left over
  // from the previous point or dataset is emptied in ST_P_RD, which the check leaves out.
  a_heap_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_LOAD && state_r != ST_P_RD) |->
    ($countones(heap_valid) <= 32'(k_eff)))
    else $error("neighbor list holds more than k entries");

  // The fill count tracks the filled cells of the ranked list.
  a_rank_count: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(rank_valid) == 32'(rank_cnt_r))
    else $error("ranked list count out of step with its cells");

  // The cutoff only rises once the ranked list is full; the report drains the list.
  a_cutoff_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_REPORT && rank_cnt_r < n_eff) |-> (cutoff_r == '0))
    else $error("cutoff set before the ranked list filled");

  // Taking the final report word returns the block to loading with an empty list.
  a_report_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && out_word.last_result) |=> (state_r == ST_LOAD && rank_cnt_r == '0))
    else $error("report did not close the dataset");

endmodule
